// ----- hdl/itda_pkg.sv -----
package itda_pkg;

  // Default width of the signed input value
  localparam int unsigned VALUE_WIDTH_DEF = 32;

  // Result field widths
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned COUNT_W = 4;

  // ASCII codes
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

  // Controller to datapath commands
  typedef struct packed {
    logic load;     // capture sign and magnitude of a new value
    logic step;     // one shift-add-3 step of the BCD converter
    logic size;     // count characters and load the first one
    logic advance;  // load the next digit character
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic conv_done;  // current step is the last converter step
    logic last_char;  // output register holds the final character
  } status_t;

endpackage

// ----- hdl/int_to_decimal_ascii.sv -----
// Signed integer to decimal ASCII text.
//
// Input channel: value_i with in_valid_i, held off by in_stall_o. Output
// channel: one character per transfer on ascii_char_o, with char_count_o
// (total characters of the number, same on each) and last_o on the final
// character, held off by out_stall_i. A negative value starts with '-';
// zero gives a single '0'; no leading zeros.
//
// One item at a time. After an input transfer the magnitude goes through a
// shift-add-3 binary to BCD converter, one bit per cycle, then a sizing
// step counts the characters and loads the first one. The first character
// is offered once the sizing step has loaded it and can transfer in the
// cycle it is offered; one character follows per cycle while the receiver
// takes them. The next input is taken in the cycle after the last transfer.
// While out_stall_i is high the offered character holds. Reset returns the
// block to idle and drops any item in progress.
module int_to_decimal_ascii
  import itda_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [VALUE_WIDTH-1:0] value_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic        [CHAR_W-1:0]      ascii_char_o,
  output logic        [COUNT_W-1:0]     char_count_o,
  output logic                          last_o
);

  cmd_t    cmd;
  status_t status;

  itda_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  itda_datapath #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .value_i      (value_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .ascii_char_o (ascii_char_o),
    .char_count_o (char_count_o),
    .last_o       (last_o)
  );

endmodule

// ----- hdl/itda_ctrl.sv -----
module itda_ctrl
  import itda_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CONV = 4'b0010,
    S_SIZE = 4'b0100,
    S_EMIT = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // Sequence one item: accept, convert, size, emit characters
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CONV;
        end
      end
      S_CONV: begin
        cmd_o.step = 1'b1;
        if (status_i.conv_done) begin
          state_d = S_SIZE;
        end
      end
      S_SIZE: begin
        cmd_o.size = 1'b1;
        state_d    = S_EMIT;
      end
      S_EMIT: begin
        if (!out_stall_i) begin
          if (status_i.last_char) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.advance = 1'b1;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_EMIT);

  // The final character transfer returns the block to idle
  a_last_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && status_i.last_char) |=> (state_q == S_IDLE))
    else $error("block did not return to idle after the final character");

  // At most one datapath command per cycle
  a_cmd_onehot0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.load, cmd_o.step, cmd_o.size, cmd_o.advance}))
    else $error("more than one datapath command issued");

  // A stalled character is never replaced
  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> !cmd_o.advance)
    else $error("character advanced while the receiver stalls");

endmodule

// ----- hdl/itda_datapath.sv -----
module itda_datapath
  import itda_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic signed [VALUE_WIDTH-1:0] value_i,
  input  cmd_t                          cmd_i,
  output status_t                       status_o,
  output logic        [CHAR_W-1:0]      ascii_char_o,
  output logic        [COUNT_W-1:0]     char_count_o,
  output logic                          last_o
);

  // Decimal digits of the largest magnitude, 2**(VALUE_WIDTH-1)
  localparam int unsigned NDIG = ((VALUE_WIDTH - 1) * 30103) / 100000 + 1;
  localparam int unsigned IW   = $clog2(NDIG);
  localparam int unsigned BW   = $clog2(VALUE_WIDTH);
  localparam int unsigned TW   = IW + 1;

  logic [VALUE_WIDTH-1:0]   mag_q;
  logic [VALUE_WIDTH-1:0]   abs_val;
  logic [NDIG-1:0][3:0]     bcd_q;
  logic [NDIG-1:0][3:0]     bcd_adj;
  logic [4*NDIG-1:0]        bcd_adj_flat;
  logic [BW-1:0]            bitcnt_q;
  logic                     neg_q;
  logic [IW-1:0]            idx_q;
  logic [IW-1:0]            top;
  logic [TW-1:0]            total;
  logic [CHAR_W-1:0]        char_q;
  logic [COUNT_W-1:0]       count_q;
  logic                     last_q;

  // Two's complement magnitude; the most negative value maps to 2**(W-1)
  assign abs_val = value_i[VALUE_WIDTH-1] ? (~$unsigned(value_i) + 1'b1)
                                          : $unsigned(value_i);

  // Add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      bcd_adj[i] = (bcd_q[i] >= 4'd5) ? (bcd_q[i] + 4'd3) : bcd_q[i];
    end
  end

  assign bcd_adj_flat = bcd_adj;

  // Find the most significant nonzero digit (digit 0 for zero)
  always_comb begin
    top = '0;
    for (int i = 0; i < NDIG; i++) begin
      if (bcd_q[i] != 4'd0) begin
        top = IW'(i);
      end
    end
  end

  assign total = {1'b0, top} + TW'(1) + TW'(neg_q);

  // Converter registers: load, then shift one magnitude bit in per step
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mag_q    <= abs_val;
      neg_q    <= value_i[VALUE_WIDTH-1];
      bcd_q    <= '0;
      bitcnt_q <= '0;
    end else if (cmd_i.step) begin
      bcd_q    <= {bcd_adj_flat[4*NDIG-2:0], mag_q[VALUE_WIDTH-1]};
      mag_q    <= {mag_q[VALUE_WIDTH-2:0], 1'b0};
      bitcnt_q <= bitcnt_q + 1'b1;
    end
  end

  // Output character register, pointer to the next digit
  always_ff @(posedge clk_i) begin
    if (cmd_i.size) begin
      count_q <= total[COUNT_W-1:0];
      if (neg_q) begin
        char_q <= CHAR_MINUS;
        idx_q  <= top;
        last_q <= 1'b0;
      end else begin
        char_q <= CHAR_ZERO + {4'b0000, bcd_q[top]};
        idx_q  <= top - 1'b1;
        last_q <= (top == '0);
      end
    end else if (cmd_i.advance) begin
      char_q <= CHAR_ZERO + {4'b0000, bcd_q[idx_q]};
      idx_q  <= idx_q - 1'b1;
      last_q <= (idx_q == '0);
    end
  end

  assign status_o.conv_done = (bitcnt_q == BW'(VALUE_WIDTH - 1));
  assign status_o.last_char = last_q;

  assign ascii_char_o = char_q;
  assign char_count_o = count_q;
  assign last_o       = last_q;

  // Never advance past the final character
  a_no_advance_past_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.advance |-> !last_q)
    else $error("advance issued after the final character");

  // First character is a minus sign or a decimal digit
  a_first_char_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.size |=> ((char_q == CHAR_MINUS) ||
                    ((char_q >= CHAR_ZERO) && (char_q <= CHAR_ZERO + 8'd9))))
    else $error("first character is not a minus sign or a digit");

  // Each digit loaded by an advance is a decimal digit
  a_bcd_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.advance |-> (bcd_q[idx_q] <= 4'd9))
    else $error("converted digit out of decimal range");

endmodule

// ----- verif/int_to_decimal_ascii_tb.sv -----
`timescale 1ns / 100ps

module int_to_decimal_ascii_tb;
  import itda_pkg::*;

  localparam int unsigned VW          = VALUE_WIDTH_DEF;
  localparam int unsigned CYCLE_LIMIT = 400_000;
  localparam int unsigned DRAIN_LIMIT = 5_000;
  // conversion pass plus sizing plus the longest text
  localparam int unsigned TAIL_CYCLES = VW + 2 + 11 + 8;
  localparam int unsigned RAND_PER_MIX = 60;

  // One expected character of a number's text
  typedef struct packed {
    logic [CHAR_W-1:0]  ascii;
    logic [COUNT_W-1:0] count;
    logic               last;
  } char_exp_t;

  // Directed row: empty text means the predictor supplies it
  typedef struct {
    logic [VW-1:0] value;
    string         text;
  } dir_row_t;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  logic signed [VW-1:0] value_i     = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [CHAR_W-1:0]    ascii_char_o;
  logic [COUNT_W-1:0]   char_count_o;
  logic                 last_o;

  char_exp_t   pending_chars[$];
  char_exp_t   head_char;
  int unsigned fail_cnt      = 0;
  int unsigned chars_checked = 0;
  int unsigned numbers_sent  = 0;
  int unsigned cycle_cnt     = 0;
  int unsigned in_idle_pct   = 0;
  int unsigned out_stall_pct = 0;

  dir_row_t dir_tab [20];

  int_to_decimal_ascii #(.VALUE_WIDTH(VW)) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .ascii_char_o(ascii_char_o),
    .char_count_o(char_count_o),
    .last_o      (last_o)
  );

  // 10 ns clock
  always #5 clk_i = ~clk_i;

  // Count cycles for the watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  initial begin : watchdog
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("timeout after %0d cycles", cycle_cnt);
    $display("end of test: mismatches");
    $finish;
  end

  // Decimal text of a value, most significant character first
  function automatic void decimal_text(input logic [VW-1:0] raw,
                                       output logic [CHAR_W-1:0] txt[$]);
    logic          neg;
    logic [VW-1:0] mag;
    txt = {};
    neg = raw[VW-1];
    // the most negative value wraps back onto itself: read it unsigned
    mag = neg ? (~raw + 1'b1) : raw;
    do begin
      txt.push_front(CHAR_ZERO + CHAR_W'(mag % 10));
      mag = mag / 10;
    end while (mag != 0);
    if (neg) txt.push_front(CHAR_MINUS);
  endfunction

  // Queue one expected transfer per character
  function automatic void queue_text(input logic [CHAR_W-1:0] txt[$]);
    char_exp_t c;
    for (int i = 0; i < txt.size(); i++) begin
      c.ascii = txt[i];
      c.count = COUNT_W'(txt.size());
      c.last  = (i == txt.size() - 1);
      pending_chars.push_back(c);
    end
  endfunction

  // Random value biased toward digit-count boundaries and small magnitudes
  function automatic logic [VW-1:0] pick_value();
    logic [VW-1:0] v;
    logic [VW-1:0] p;
    int unsigned   k;
    case ($urandom_range(5))
      0: v = $urandom_range(0, 99);
      1: begin
        k = $urandom_range(1, 9);
        p = 1;
        for (int i = 0; i < k; i++) p = p * 10;
        v = p + $urandom_range(0, 2) - 1;
      end
      2: v = $urandom >> $urandom_range(0, VW - 1);
      3: begin
        case ($urandom_range(3))
          0: v = {1'b0, {(VW-1){1'b1}}};
          1: v = {1'b1, {(VW-1){1'b0}}};
          2: v = '0;
          default: v = '1;
        endcase
      end
      default: v = $urandom;
    endcase
    if ($urandom_range(1)) v = -v;
    return v;
  endfunction

  // Offer one value, idle first by the current mix, hold until transfer
  task automatic send_value(input logic [VW-1:0] v, input logic [CHAR_W-1:0] txt[$]);
    @(negedge clk_i);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      value_i    <= $urandom;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    value_i    <= v;
    do @(posedge clk_i); while (in_stall_o);
    queue_text(txt);
    numbers_sent++;
  endtask

  // Drop valid and hold off until every expected character has come
  task automatic wait_for_drain();
    int unsigned waited;
    waited = 0;
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_chars.size() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (TAIL_CYCLES) @(negedge clk_i);
  endtask

  // Receiver stall, redrawn every cycle
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < out_stall_pct);
  end

  // Compare each character transfer with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_chars.size() == 0) begin
        $error("unexpected character transfer: ascii_char %h", ascii_char_o);
        fail_cnt++;
      end else begin
        head_char = pending_chars.pop_front();
        chars_checked++;
        if (ascii_char_o !== head_char.ascii) begin
          $error("ascii_char: expected %h, got %h", head_char.ascii, ascii_char_o);
          fail_cnt++;
        end
        if (char_count_o !== head_char.count) begin
          $error("char_count: expected %0d, got %0d", head_char.count, char_count_o);
          fail_cnt++;
        end
        if (last_o !== head_char.last) begin
          $error("last: expected %b, got %b", head_char.last, last_o);
          fail_cnt++;
        end
      end
    end
  end

  initial begin : stimulus
    logic [CHAR_W-1:0] txt[$];
    logic [VW-1:0]     v;

    dir_tab = '{
      '{32'd0,          "0"},
      '{32'd1,          "1"},
      '{-32'sd1,        "-1"},
      '{32'd9,          "9"},
      '{32'd10,         "10"},
      '{-32'sd10,       "-10"},
      '{32'd99,         "99"},
      '{32'd100,        "100"},
      '{32'h7FFF_FFFF,  "2147483647"},
      '{32'h8000_0000,  "-2147483648"},
      '{32'h8000_0001,  "-2147483647"},
      '{32'd999999999,  "999999999"},
      '{32'd1000000000, "1000000000"},
      '{-32'sd999999999, "-999999999"},
      '{32'd1234567890, ""},
      '{32'h5555_5555,  ""},
      '{32'hAAAA_AAAA,  ""},
      '{32'h0000_FFFF,  ""},
      '{32'hFFFF_0000,  ""},
      '{32'h0F0F_F0F0,  ""}
    };

    // Hold reset low, then release it
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed rows, no idling
    foreach (dir_tab[r]) begin
      if (dir_tab[r].text.len() == 0) begin
        decimal_text(dir_tab[r].value, txt);
      end else begin
        txt = {};
        for (int i = 0; i < dir_tab[r].text.len(); i++) txt.push_back(dir_tab[r].text[i]);
      end
      send_value(dir_tab[r].value, txt);
    end
    wait_for_drain();

    // Random values under each idle/stall mix, draining between mixes
    for (int mix = 0; mix < 4; mix++) begin
      case (mix)
        0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
        1: begin in_idle_pct = 53; out_stall_pct = 0;  end
        2: begin in_idle_pct = 0;  out_stall_pct = 53; end
        default: begin in_idle_pct = 7; out_stall_pct = 7; end
      endcase
      for (int n = 0; n < RAND_PER_MIX; n++) begin
        v = pick_value();
        decimal_text(v, txt);
        send_value(v, txt);
      end
      wait_for_drain();
    end

    if (pending_chars.size() != 0) begin
      $error("%0d expected characters never arrived", pending_chars.size());
      fail_cnt++;
    end

    $display("converted %0d numbers into %0d checked characters,", numbers_sent, chars_checked);
    $display("with sender gaps and receiver stalls mixed across four phases");
    if (fail_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/itda_pkg.sv
hdl/itda_ctrl.sv
hdl/itda_datapath.sv
hdl/int_to_decimal_ascii.sv
verif/int_to_decimal_ascii_tb.sv
